### hw/rtl/stb_pkg.sv
// Shared types and constants for the spline trail ribbon builder.
// No dependencies; compiled before the interfaces and modules.
package stb_pkg;

	localparam int COORD_W = 32;
	localparam int NCOORD  = 6;
	localparam int PAIR_W  = COORD_W * NCOORD;
	localparam int SEG_W   = 5;
	localparam int LIM_W   = 9;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [SEG_W-1:0] SEG_RESET = 5'd4;
	localparam logic [LIM_W-1:0] LIM_RESET = 9'd480;

	// register select, taken from paddr[2]
	localparam logic REG_SEGMENTS   = 1'b0;
	localparam logic REG_PAIR_LIMIT = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_STOP   = 2'd2
	} stb_action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_RD,
		ST_RDW,
		ST_WA,
		ST_WB,
		ST_WC,
		ST_MAC,
		ST_ABS,
		ST_SAT,
		ST_DIV,
		ST_DFIN,
		ST_SEMIT,
		ST_NEMIT
	} stb_state_t;

	// coordinate 0 sits in the low bits of a stored pair
	function automatic logic [PAIR_W-1:0] pack_pair(input coord_t c0, input coord_t c1,
			input coord_t c2, input coord_t c3, input coord_t c4, input coord_t c5);
		pack_pair = {c5, c4, c3, c2, c1, c0};
	endfunction

endpackage

### hw/rtl/stb_ifs.sv
// Valid/ready channel interfaces for the spline trail ribbon builder.
// Depends on stb_pkg for the coordinate type.
interface stb_in_if;
	import stb_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	coord_t      high_x;
	coord_t      high_y;
	coord_t      high_z;
	coord_t      low_x;
	coord_t      low_y;
	coord_t      low_z;
	modport source (output valid, action, high_x, high_y, high_z, low_x, low_y, low_z,
		input ready);
	modport sink (input valid, action, high_x, high_y, high_z, low_x, low_y, low_z,
		output ready);
endinterface

interface stb_out_if #(parameter int TOTAL_W = 10);
	import stb_pkg::*;
	logic               valid;
	logic               ready;
	coord_t             out_high_x;
	coord_t             out_high_y;
	coord_t             out_high_z;
	coord_t             out_low_x;
	coord_t             out_low_y;
	coord_t             out_low_z;
	logic               render_on;
	logic [TOTAL_W-1:0] pair_total;
	logic               last;
	modport source (output valid, out_high_x, out_high_y, out_high_z, out_low_x, out_low_y,
		out_low_z, render_on, pair_total, last, input ready);
	modport sink (input valid, out_high_x, out_high_y, out_high_z, out_low_x, out_low_y,
		out_low_z, render_on, pair_total, last, output ready);
endinterface

### hw/rtl/stb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module stb_ram #(
	parameter int WIDTH = 192,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/spline_trail_ribbon_builder_unit.sv
// Spline trail ribbon builder: ring store of point pairs in one RAM, Catmull-Rom
// points made by one shared multiply-accumulate and a bit-serial divider.
// Depends on stb_pkg, stb_ifs (stb_in_if, stb_out_if) and stb_ram.
//
// channel  | dir | handshake        | payload
// in_ch    | in  | valid/ready      | action, high_x..z, low_x..z
// out_ch   | out | valid/ready      | out_high_x..out_low_z, render_on, pair_total, last
// apb      | in  | psel/penable     | paddr[2] selects segments or pair_limit
//
// Start, stop, unused actions and short updates emit straight from the decode state.
// Full update: for each of S segments, each coordinate is accumulated over its four control
// points, then divided in 31 divider steps, one quotient bit per cycle, unless it saturates.
// One item is worked at a time; input is taken again once the last result sits
// in the output register. A stalled output holds the sequencer before each emit.
// Reset clears pointer, count, flag and registers; the pair RAM is not cleared.
module spline_trail_ribbon_builder_unit #(
	parameter int STORE_PAIRS  = 512,
	parameter int MAX_SEGMENTS = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	stb_in_if.sink                      in_ch,
	stb_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stb_pkg::APB_AW-1:0]  paddr,
	input  logic [stb_pkg::APB_DW-1:0]  pwdata,
	output logic [stb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import stb_pkg::*;

	localparam int AW    = $clog2(STORE_PAIRS);
	localparam int CW    = $clog2(STORE_PAIRS + 1);
	localparam int SW    = $clog2(MAX_SEGMENTS + 1);
	localparam int SCW   = (SW > SEG_W) ? SW : SEG_W;
	localparam int IW    = ((CW > SW) ? CW : SW) + 2;
	localparam int FW    = ((IW > LIM_W) ? IW : LIM_W) + 1;
	localparam int WW    = 3 * SW + 4;
	localparam int PW    = COORD_W + WW;
	localparam int ACCW  = PW + 3;
	localparam int DENW  = 3 * SW + 1;
	localparam int QW    = COORD_W - 1;

	// ---------------- registers ----------------
	stb_state_t state_q, state_d;
	logic [AW-1:0]    fp_q, wp_q, hi_addr_q, lo_addr_q;
	logic [CW-1:0]    cnt_q, fin_q;
	logic             render_q;
	logic [SEG_W-1:0] seg_q;
	logic [LIM_W-1:0] lim_q;
	logic [1:0]       act_q;
	logic             hi_sel_q, lo_sel_q;
	logic [1:0]       rd_cnt_q;
	logic             rd_vld_s1;
	logic [1:0]       rd_idx_s1;
	logic [SW-1:0]    s_q, n_q;
	logic [2*SW-1:0]  n2_q, nd_q, d2_q;
	logic [3*SW-1:0]  n3_q, n2d_q, nd2_q, d3_q;
	logic signed [WW-1:0] w_q [4];
	logic [DENW-1:0]  den_q;
	coord_t           ops_q [NCOORD][4];
	coord_t           pt_q [NCOORD];
	logic [2:0]       coord_q;
	logic [1:0]       term_q;
	logic signed [ACCW-1:0] acc_q;
	logic [ACCW-1:0]  mag_q;
	logic             neg_q;
	logic [DENW-1:0]  rem_q;
	logic [QW-1:0]    low_q, quo_q;
	logic [4:0]       it_q;
	logic             ov_q;
	coord_t           out_pt_q [NCOORD];
	logic             out_last_q, out_render_q;
	logic [CW-1:0]    out_total_q;

	// ---------------- RAM ----------------
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [PAIR_W-1:0] ram_wdata, ram_rdata;

	stb_ram #(.WIDTH(PAIR_W), .DEPTH(STORE_PAIRS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (AW+1)'(STORE_PAIRS)) begin
			sum = sum - (AW+1)'(STORE_PAIRS);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
		return (a == '0) ? AW'(STORE_PAIRS - 1) : a - AW'(1);
	endfunction

	// ---------------- APB ----------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_PAIR_LIMIT) ? APB_DW'(lim_q) : APB_DW'(seg_q);

	// ---------------- decode helpers ----------------
	logic [SCW-1:0] seg_x, s_eff;
	logic [SW-1:0]  s_dec;
	logic [IW-1:0]  two_c, hi_idx, lo_idx, hi_try, lo_try;
	logic [FW-1:0]  fin_sum, fin_cap;
	logic [AW-1:0]  hi_pair, lo_pair;
	logic           can_emit;

	always_comb begin
		seg_x = SCW'(seg_q);
		if (seg_x == '0) begin
			s_eff = SCW'(1);
		end else if (seg_x > SCW'(MAX_SEGMENTS)) begin
			s_eff = SCW'(MAX_SEGMENTS);
		end else begin
			s_eff = seg_x;
		end
		s_dec  = s_eff[SW-1:0];
		two_c  = IW'(cnt_q) << 1;
		hi_try = IW'(s_dec) + IW'(2);
		lo_try = IW'(s_dec) + IW'(3);
		hi_idx = (hi_try < two_c - IW'(2)) ? hi_try : two_c - IW'(2);
		lo_idx = (lo_try < two_c - IW'(1)) ? lo_try : two_c - IW'(1);
		hi_pair = AW'(hi_idx >> 1);
		lo_pair = AW'(lo_idx >> 1);
		fin_sum = FW'(cnt_q) + FW'(s_dec);
		fin_cap = (fin_sum > FW'(STORE_PAIRS)) ? FW'(STORE_PAIRS) : fin_sum;
		if (fin_cap > FW'(lim_q)) begin
			fin_cap = FW'(lim_q);
		end
	end

	assign can_emit = !ov_q || out_ch.ready;

	// ---------------- arithmetic ----------------
	coord_t                 mac_op;
	logic signed [PW-1:0]   prod;
	logic [ACCW-1:0]        sat_lim;
	logic [DENW:0]          div_t;
	logic                   div_ge;
	logic [COORD_W-1:0]     qq;

	assign mac_op  = ops_q[coord_q][term_q];
	assign prod    = PW'(mac_op) * PW'(w_q[term_q]);
	assign sat_lim = ACCW'(den_q) << QW;
	assign div_t   = {rem_q, low_q[QW-1]};
	assign div_ge  = div_t >= {1'b0, den_q};
	assign qq      = {1'b0, quo_q} + COORD_W'(neg_q && (rem_q != '0));

	// ---------------- control ----------------
	typedef enum logic [1:0] {EM_ZERO, EM_NEW, EM_PT} em_src_t;
	em_src_t em_src;
	logic    emit, em_last, em_render;
	logic [CW-1:0] em_total;

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		em_src    = EM_ZERO;
		em_last   = 1'b1;
		em_render = render_q;
		em_total  = cnt_q;
		ram_we    = 1'b0;
		ram_waddr = ring_dec(fp_q);
		ram_wdata = pack_pair(ops_q[0][3], ops_q[1][3], ops_q[2][3],
			ops_q[3][3], ops_q[4][3], ops_q[5][3]);
		ram_re    = 1'b0;
		ram_raddr = hi_addr_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (can_emit) begin
					case (act_q)
						ACT_START: begin
							emit     = 1'b1;
							em_src   = EM_NEW;
							em_total = CW'(1);
							ram_we   = 1'b1;
							state_d  = ST_IDLE;
						end
						ACT_STOP: begin
							emit     = 1'b1;
							em_total = '0;
							state_d  = ST_IDLE;
						end
						ACT_UPDATE: begin
							if (cnt_q < CW'(2)) begin
								emit      = 1'b1;
								em_src    = EM_NEW;
								em_render = 1'b0;
								em_total  = cnt_q + CW'(1);
								ram_we    = 1'b1;
								state_d   = ST_IDLE;
							end else begin
								state_d = ST_RD;
							end
						end
						default: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD: begin
				ram_re = 1'b1;
				case (rd_cnt_q)
					2'd0: ram_raddr = hi_addr_q;
					2'd1: ram_raddr = lo_addr_q;
					2'd2: ram_raddr = ring_add(fp_q, AW'(1));
					default: ram_raddr = fp_q;
				endcase
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_RDW;
				end
			end
			ST_RDW: state_d = ST_WA;
			ST_WA: state_d = ST_WB;
			ST_WB: state_d = ST_WC;
			ST_WC: state_d = ST_MAC;
			ST_MAC: begin
				if (term_q == 2'd3) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS: state_d = ST_SAT;
			ST_SAT: begin
				if (mag_q >= sat_lim) begin
					state_d = (coord_q == 3'(NCOORD - 1)) ? ST_SEMIT : ST_MAC;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (it_q == 5'(QW - 1)) begin
					state_d = ST_DFIN;
				end
			end
			ST_DFIN: state_d = (coord_q == 3'(NCOORD - 1)) ? ST_SEMIT : ST_MAC;
			ST_SEMIT: begin
				if (can_emit) begin
					emit      = 1'b1;
					em_src    = EM_PT;
					em_last   = 1'b0;
					em_render = 1'b1;
					em_total  = fin_q;
					ram_we    = 1'b1;
					ram_waddr = wp_q;
					ram_wdata = pack_pair(pt_q[0], pt_q[1], pt_q[2], pt_q[3], pt_q[4], pt_q[5]);
					state_d   = (n_q == s_q) ? ST_NEMIT : ST_WA;
				end
			end
			ST_NEMIT: begin
				if (can_emit) begin
					emit      = 1'b1;
					em_src    = EM_NEW;
					em_render = 1'b1;
					em_total  = fin_q;
					ram_we    = 1'b1;
					ram_waddr = wp_q;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q      <= '0;
			cnt_q     <= '0;
			render_q  <= 1'b0;
			seg_q     <= SEG_RESET;
			lim_q     <= LIM_RESET;
			ov_q      <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_cnt_q  <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_PAIR_LIMIT) begin
					lim_q <= pwdata[LIM_W-1:0];
				end else begin
					seg_q <= pwdata[SEG_W-1:0];
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			rd_vld_s1 <= ram_re;
			if (state_q == ST_DEC) begin
				rd_cnt_q <= '0;
			end else if (state_q == ST_RD) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end
			if (emit && state_q == ST_DEC) begin
				case (act_q)
					ACT_START: begin
						fp_q  <= ring_dec(fp_q);
						cnt_q <= CW'(1);
					end
					ACT_STOP: cnt_q <= '0;
					ACT_UPDATE: begin
						fp_q     <= ring_dec(fp_q);
						cnt_q    <= cnt_q + CW'(1);
						render_q <= 1'b0;
					end
					default: cnt_q <= cnt_q;
				endcase
			end
			if (emit && state_q == ST_NEMIT) begin
				fp_q     <= wp_q;
				cnt_q    <= fin_q;
				render_q <= 1'b1;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q;
		if (emit) begin
			out_last_q   <= em_last;
			out_render_q <= em_render;
			out_total_q  <= em_total;
			for (int j = 0; j < NCOORD; j++) begin
				case (em_src)
					EM_NEW:  out_pt_q[j] <= ops_q[j][3];
					EM_PT:   out_pt_q[j] <= pt_q[j];
					default: out_pt_q[j] <= '0;
				endcase
			end
		end
		if (state_q == ST_IDLE && in_ch.valid) begin
			act_q       <= in_ch.action;
			ops_q[0][3] <= in_ch.high_x;
			ops_q[1][3] <= in_ch.high_y;
			ops_q[2][3] <= in_ch.high_z;
			ops_q[3][3] <= in_ch.low_x;
			ops_q[4][3] <= in_ch.low_y;
			ops_q[5][3] <= in_ch.low_z;
		end
		if (state_q == ST_DEC) begin
			s_q       <= s_dec;
			n_q       <= SW'(1);
			fin_q     <= CW'(fin_cap);
			hi_sel_q  <= hi_idx[0];
			lo_sel_q  <= lo_idx[0];
			hi_addr_q <= ring_add(fp_q, hi_pair);
			lo_addr_q <= ring_add(fp_q, lo_pair);
			wp_q      <= fp_q;
		end
		// stored pair: high point in fields 0..2, low point in fields 3..5
		if (rd_vld_s1) begin
			for (int j = 0; j < 3; j++) begin
				case (rd_idx_s1)
					2'd0: ops_q[j][0] <= hi_sel_q ? ram_rdata[COORD_W*(3+j) +: COORD_W]
						: ram_rdata[COORD_W*j +: COORD_W];
					2'd1: ops_q[3+j][0] <= lo_sel_q ? ram_rdata[COORD_W*(3+j) +: COORD_W]
						: ram_rdata[COORD_W*j +: COORD_W];
					2'd2: begin
						ops_q[j][1]   <= ram_rdata[COORD_W*j +: COORD_W];
						ops_q[3+j][1] <= ram_rdata[COORD_W*(3+j) +: COORD_W];
					end
					default: begin
						ops_q[j][2]   <= ram_rdata[COORD_W*j +: COORD_W];
						ops_q[3+j][2] <= ram_rdata[COORD_W*(3+j) +: COORD_W];
					end
				endcase
			end
		end
		case (state_q)
			ST_WA: begin
				n2_q <= (2*SW)'(n_q) * (2*SW)'(n_q);
				nd_q <= (2*SW)'(n_q) * (2*SW)'(s_q);
				d2_q <= (2*SW)'(s_q) * (2*SW)'(s_q);
			end
			ST_WB: begin
				n3_q  <= (3*SW)'(n2_q) * (3*SW)'(n_q);
				n2d_q <= (3*SW)'(n2_q) * (3*SW)'(s_q);
				nd2_q <= (3*SW)'(nd_q) * (3*SW)'(s_q);
				d3_q  <= (3*SW)'(d2_q) * (3*SW)'(s_q);
			end
			ST_WC: begin
				w_q[0] <= ($signed(WW'(n2d_q)) <<< 1) - $signed(WW'(n3_q))
					- $signed(WW'(nd2_q));
				w_q[1] <= ($signed(WW'(n3_q)) <<< 1) + $signed(WW'(n3_q))
					- ($signed(WW'(n2d_q)) <<< 2) - $signed(WW'(n2d_q))
					+ ($signed(WW'(d3_q)) <<< 1);
				w_q[2] <= ($signed(WW'(n2d_q)) <<< 2) + $signed(WW'(nd2_q))
					- ($signed(WW'(n3_q)) <<< 1) - $signed(WW'(n3_q));
				w_q[3] <= $signed(WW'(n3_q)) - $signed(WW'(n2d_q));
				den_q   <= {d3_q, 1'b0};
				coord_q <= '0;
				term_q  <= '0;
				acc_q   <= $signed(ACCW'(d3_q));
			end
			ST_MAC: begin
				acc_q  <= acc_q + ACCW'(prod);
				term_q <= term_q + 2'd1;
			end
			ST_ABS: begin
				neg_q <= acc_q[ACCW-1];
				mag_q <= acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
			end
			ST_SAT: begin
				rem_q <= mag_q[QW +: DENW];
				low_q <= mag_q[QW-1:0];
				quo_q <= '0;
				it_q  <= '0;
				if (mag_q >= sat_lim) begin
					// clamp to the signed 32-bit range
					pt_q[coord_q] <= neg_q ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
					coord_q       <= coord_q + 3'd1;
					term_q        <= '0;
					acc_q         <= $signed(ACCW'(d3_q));
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? DENW'(div_t - {1'b0, den_q}) : DENW'(div_t);
				quo_q <= {quo_q[QW-2:0], div_ge};
				low_q <= low_q << 1;
				it_q  <= it_q + 5'd1;
			end
			ST_DFIN: begin
				// floor division: a negative numerator with remainder rounds down
				pt_q[coord_q] <= neg_q ? -qq : qq;
				coord_q       <= coord_q + 3'd1;
				term_q        <= '0;
				acc_q         <= $signed(ACCW'(d3_q));
			end
			ST_SEMIT: begin
				if (emit) begin
					wp_q <= ring_dec(wp_q);
					n_q  <= n_q + SW'(1);
				end
			end
			default: begin
				term_q <= term_q;
			end
		endcase
	end

	// ---------------- output ----------------
	assign out_ch.valid      = ov_q;
	assign out_ch.out_high_x = out_pt_q[0];
	assign out_ch.out_high_y = out_pt_q[1];
	assign out_ch.out_high_z = out_pt_q[2];
	assign out_ch.out_low_x  = out_pt_q[3];
	assign out_ch.out_low_y  = out_pt_q[4];
	assign out_ch.out_low_z  = out_pt_q[5];
	assign out_ch.render_on  = out_render_q;
	assign out_ch.pair_total = out_total_q;
	assign out_ch.last       = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STORE_PAIRS))
		else $error("pair count above store depth");
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !ram_we)
		else $error("store written while control points in flight");
	a_point_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEMIT) |-> (n_q != '0 && n_q <= s_q))
		else $error("spline point index out of range");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> ov_q)
		else $error("pending result dropped");
`endif

endmodule
